[sv/swm_pkg.sv]
// Shared constants, types and state encoding for the sliding-window maximum block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_WIDTH    = 7;
    localparam int ADDR_WIDTH   = $clog2(MAX_WINDOW);
    localparam int CNT_WIDTH    = $clog2(MAX_WINDOW + 1);
    localparam int POS_WIDTH    = $clog2(4 * MAX_WINDOW);

    // one queue entry: candidate value and its arrival position
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [POS_WIDTH-1:0]           pos;
    } t_entry;

    typedef struct packed {
        logic                  en;
        logic [ADDR_WIDTH-1:0] addr;
        t_entry                entry;
    } t_mem_wr;

    typedef struct packed {
        logic                  en;
        logic [ADDR_WIDTH-1:0] addr;
    } t_mem_rd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CHK,
        S_POP_RD,
        S_POP_CHK,
        S_PUSH,
        S_FRONT_RD,
        S_OUT
    } t_state;

endpackage

[sv/swm_if.sv]
// Valid/ready channel interfaces: input items, result items, window_size writes.
// Depends on swm_pkg.
`timescale 1ns / 1ps

interface swm_in_if import swm_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_WIDTH-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

[sv/sliding_window_maximum_top.sv]
// Sliding-window maximum over signed samples, kept as a monotonic queue in memory.
// Depends on swm_pkg, swm_if and swm_queue_mem.
//
//   channel   | dir | payload                    | accepted when
//   i_in_ch   | in  | sample, start_req          | valid && ready
//   o_out_ch  | out | window_max                 | valid && ready
//   i_cfg_ch  | in  | window_size                | valid && ready (always ready)
//
// One item at a time: each queue entry dropped (expired at the front or smaller
// at the back) costs one read-and-compare pair, since the queue memory has a
// single read port and one entry is examined per read-and-compare pair.
// Reset clears the control state; the queue memory is not cleared and
// needs no clearing pass. A stalled result waits in the output register; the
// next item is taken while it waits, and its result waits for that slot.
`timescale 1ns / 1ps

module sliding_window_maximum_top import swm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    swm_in_if.sink    i_in_ch,
    swm_out_if.source o_out_ch,
    swm_cfg_if.sink   i_cfg_ch
);

    t_state r_state, n_state;

    logic [CFG_WIDTH-1:0]           r_window;
    logic [POS_WIDTH-1:0]           r_pos, n_pos;
    logic [ADDR_WIDTH-1:0]          r_head, n_head;
    logic [CNT_WIDTH-1:0]           r_count, n_count;
    logic [CNT_WIDTH-1:0]           r_fill, n_fill;
    logic signed [SAMPLE_WIDTH-1:0] r_sample, n_sample;
    logic                           r_out_valid, n_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data, n_out_data;

    logic [CNT_WIDTH-1:0]  w_win;
    logic [ADDR_WIDTH-1:0] w_tail;
    logic [ADDR_WIDTH-1:0] w_last;
    logic [POS_WIDTH-1:0]  w_age;
    logic                  w_expired;
    logic                  w_smaller;
    logic [CNT_WIDTH-1:0]  w_fill_inc;
    logic                  w_has_result;
    logic                  w_in_accept;
    logic                  w_out_free;

    t_mem_wr w_wr;
    t_mem_rd w_rd;
    t_entry  w_rd_entry;

    swm_queue_mem u_mem (
        .i_clk      (i_clk),
        .i_wr       (w_wr),
        .i_rd       (w_rd),
        .o_rd_entry (w_rd_entry)
    );

    // clamp the window register to 1..MAX_WINDOW
    always_comb begin
        if (r_window == '0) begin
            w_win = CNT_WIDTH'(1);
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            w_win = CNT_WIDTH'(MAX_WINDOW);
        end else begin
            w_win = CNT_WIDTH'(r_window);
        end
    end

    // queue pointers and comparisons on the entry just read
    assign w_tail       = r_head + r_count[ADDR_WIDTH-1:0];
    assign w_last       = w_tail - ADDR_WIDTH'(1);
    assign w_age        = r_pos - w_rd_entry.pos;
    assign w_expired    = 32'(w_age) >= 32'(w_win);
    assign w_smaller    = w_rd_entry.value < r_sample;
    assign w_fill_inc   = (32'(r_fill) < 32'(MAX_WINDOW)) ? r_fill + CNT_WIDTH'(1) : r_fill;
    assign w_has_result = 32'(w_fill_inc) >= 32'(w_win);
    assign w_in_accept  = i_in_ch.valid && i_in_ch.ready;
    assign w_out_free   = !r_out_valid || o_out_ch.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) n_state = S_EXP_RD;
            end
            S_EXP_RD: begin
                n_state = (r_count == '0) ? S_PUSH : S_EXP_CHK;
            end
            S_EXP_CHK: begin
                n_state = w_expired ? S_EXP_RD : S_POP_RD;
            end
            S_POP_RD: begin
                n_state = (r_count == '0) ? S_PUSH : S_POP_CHK;
            end
            S_POP_CHK: begin
                n_state = w_smaller ? S_POP_RD : S_PUSH;
            end
            S_PUSH: begin
                n_state = w_has_result ? S_FRONT_RD : S_IDLE;
            end
            S_FRONT_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory requests and handshake outputs
    always_comb begin
        w_rd.en          = 1'b0;
        w_rd.addr        = r_head;
        w_wr.en          = 1'b0;
        w_wr.addr        = w_tail;
        w_wr.entry.value = r_sample;
        w_wr.entry.pos   = r_pos;
        unique case (r_state)
            S_EXP_RD: begin
                w_rd.en   = (r_count != '0);
                w_rd.addr = r_head;
            end
            S_POP_RD: begin
                w_rd.en   = (r_count != '0);
                w_rd.addr = w_last;
            end
            S_PUSH: begin
                w_wr.en = 1'b1;
            end
            S_FRONT_RD: begin
                w_rd.en   = 1'b1;
                w_rd.addr = r_head;
            end
            default: begin
                w_rd.en = 1'b0;
            end
        endcase
    end

    assign i_in_ch.ready       = (r_state == S_IDLE);
    assign i_cfg_ch.ready      = 1'b1;
    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.window_max = r_out_data;

    // datapath: take the item, drop front and back entries, push, load result
    always_comb begin
        n_pos       = r_pos;
        n_head      = r_head;
        n_count     = r_count;
        n_fill      = r_fill;
        n_sample    = r_sample;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_sample = i_in_ch.sample;
                    if (i_in_ch.start_req) begin
                        n_count = '0;
                        n_fill  = '0;
                    end
                end
            end
            S_EXP_CHK: begin
                if (w_expired) begin
                    n_head  = r_head + ADDR_WIDTH'(1);
                    n_count = r_count - CNT_WIDTH'(1);
                end
            end
            S_POP_CHK: begin
                if (w_smaller) n_count = r_count - CNT_WIDTH'(1);
            end
            S_PUSH: begin
                n_count = r_count + CNT_WIDTH'(1);
                n_pos   = r_pos + POS_WIDTH'(1);
                n_fill  = w_fill_inc;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_rd_entry.value;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= CFG_WIDTH'(1);
            r_pos       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_head      <= n_head;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                r_window <= i_cfg_ch.window_size;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_out_data <= n_out_data;
    end

endmodule

[sv/swm_queue_mem.sv]
// Candidate queue storage: one write port, one registered read port.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_queue_mem import swm_pkg::*; (
    input  logic    i_clk,
    input  t_mem_wr i_wr,
    input  t_mem_rd i_rd,
    output t_entry  o_rd_entry
);

    t_entry mem [MAX_WINDOW];
    t_entry r_rd_entry;

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.entry;
        end
    end

    // read one entry, data valid the next cycle and held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_entry <= mem[i_rd.addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

[sv/swm_checker.sv]
// Port-level checks for sliding_window_maximum_top, attached by bind.
// Depends on swm_pkg and swm_if.
`timescale 1ns / 1ps

module swm_checker import swm_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    swm_in_if.sink    i_in_ch,
    swm_out_if.source o_out_ch,
    swm_cfg_if.sink   i_cfg_ch
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && !o_out_ch.ready |=> o_out_ch.valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && !o_out_ch.ready |=> $stable(o_out_ch.window_max))
        else $error("result changed while stalled");

    // one item in work at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.valid && i_in_ch.ready |=> !i_in_ch.ready)
        else $error("item taken while another is in work");

    // a new result appears only as the block goes back to waiting for input
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_ch.valid) |-> i_in_ch.ready && i_cfg_ch.ready)
        else $error("result appeared while item still in work");

    // reset clears the result slot
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_ch.valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_maximum_top swm_checker u_swm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_in_ch  (i_in_ch),
    .o_out_ch (o_out_ch),
    .i_cfg_ch (i_cfg_ch)
);

[test/tb_top.sv]
// Self-checking testbench for sliding_window_maximum_top: directed rows, then random phases.
// Depends on swm_pkg, the swm_if channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_top import swm_pkg::*; ();

    localparam int     CLK_HALF_NS   = 6;
    localparam int     RESET_CYCLES  = 12;
    localparam int     RAND_ITEMS    = 1250;
    // longest item: one read-and-compare per dropped entry, both ends of a full queue
    localparam int     SETTLE_CYCLES = 300;
    localparam longint TIMEOUT_NS    = 40_000_000;
    localparam int     N_DIR         = 22;
    localparam int     N_CORNER      = 8;
    localparam int     EXP_DEPTH     = 8;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_VALUE} t_check;

    typedef struct {
        t_row_kind                      kind;
        logic [CFG_WIDTH-1:0]           win;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           start;
        t_check                         check;
        logic signed [SAMPLE_WIDTH-1:0] want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();
    swm_cfg_if cfg_ch ();

    sliding_window_maximum_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    // predictor state: the candidate queue, positions and fill count
    logic signed [SAMPLE_WIDTH-1:0] cand_val [MAX_WINDOW];
    logic [POS_WIDTH-1:0]           cand_pos [MAX_WINDOW];
    int                             cand_cnt;
    int                             fill_cnt;
    logic [POS_WIDTH-1:0]           pos_ctr;
    logic [CFG_WIDTH-1:0]           win_reg;

    // expected results not yet seen on the output, oldest first
    logic signed [SAMPLE_WIDTH-1:0] exp_fifo [EXP_DEPTH];
    int                             exp_wr;
    int                             exp_rd;
    int                             exp_level;
    int                             mismatch_cnt;
    int                             send_idle_pct;
    int                             recv_idle_pct;

    logic [CFG_WIDTH-1:0] corner_windows [N_CORNER] =
        '{7'd64, 7'd127, 7'd0, 7'd65, 7'd2, 7'd63, 7'd1, 7'd100};

    // directed rows; typed results only where they are obvious
    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_ITEM, 7'd0,   32'sh7FFF_FFFF, 1'b0, CHECK_VALUE, 32'sh7FFF_FFFF},
        '{ROW_ITEM, 7'd0,   32'sh8000_0000, 1'b0, CHECK_VALUE, 32'sh8000_0000},
        '{ROW_CFG,  7'd0,   32'sh0,         1'b0, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'shFFFF_FFFF, 1'b1, CHECK_VALUE, 32'shFFFF_FFFF},
        '{ROW_ITEM, 7'd0,   32'sh0,         1'b0, CHECK_VALUE, 32'sh0},
        '{ROW_CFG,  7'd3,   32'sh0,         1'b0, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh5,         1'b1, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh5,         1'b0, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh5,         1'b0, CHECK_VALUE, 32'sh5},
        '{ROW_ITEM, 7'd0,   32'shFFFF_FFF9, 1'b0, CHECK_VALUE, 32'sh5},
        '{ROW_ITEM, 7'd0,   32'sh9,         1'b0, CHECK_VALUE, 32'sh9},
        '{ROW_ITEM, 7'd0,   32'sh8000_0000, 1'b0, CHECK_VALUE, 32'sh9},
        '{ROW_ITEM, 7'd0,   32'shFFFF_FFF8, 1'b0, CHECK_MODEL, 32'sh0},
        '{ROW_CFG,  7'd2,   32'sh0,         1'b0, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh1,         1'b0, CHECK_MODEL, 32'sh0},
        '{ROW_CFG,  7'd127, 32'sh0,         1'b0, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh3,         1'b0, CHECK_MODEL, 32'sh0},
        '{ROW_CFG,  7'd65,  32'sh0,         1'b0, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh7FFF_FFFF, 1'b1, CHECK_NONE,  32'sh0},
        '{ROW_CFG,  7'd1,   32'sh0,         1'b0, CHECK_NONE,  32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh0,         1'b0, CHECK_VALUE, 32'sh0},
        '{ROW_ITEM, 7'd0,   32'sh7FFF_FFFF, 1'b1, CHECK_VALUE, 32'sh7FFF_FFFF}
    };

    // clock
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // append one expected result
    function automatic void exp_put(input logic signed [SAMPLE_WIDTH-1:0] v);
        exp_fifo[exp_wr] = v;
        exp_wr           = (exp_wr + 1) % EXP_DEPTH;
        exp_level++;
    endfunction

    // take the oldest expected result
    function automatic logic signed [SAMPLE_WIDTH-1:0] exp_get();
        logic signed [SAMPLE_WIDTH-1:0] v;
        v      = exp_fifo[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_DEPTH;
        exp_level--;
        return v;
    endfunction

    // advance the window by one sample; report the maximum once the window is full
    function automatic void advance_window(input logic signed [SAMPLE_WIDTH-1:0] s,
                                           input logic st, output bit has_max,
                                           output logic signed [SAMPLE_WIDTH-1:0] max_val);
        int                   w;
        int                   drop;
        logic [POS_WIDTH-1:0] pos;
        logic [POS_WIDTH-1:0] age;
        w    = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg));
        pos  = pos_ctr;
        drop = 0;
        if (st) begin
            cand_cnt = 0;
            fill_cnt = 0;
        end
        // drop front entries that have left the window
        while (drop < cand_cnt) begin
            age = pos - cand_pos[drop];
            if (age < w) break;
            drop++;
        end
        for (int i = 0; i + drop < cand_cnt; i++) begin
            cand_val[i] = cand_val[i + drop];
            cand_pos[i] = cand_pos[i + drop];
        end
        cand_cnt -= drop;
        // drop strictly smaller values from the back; equal values stay
        while (cand_cnt > 0 && cand_val[cand_cnt - 1] < s) cand_cnt--;
        if (cand_cnt >= MAX_WINDOW) begin
            for (int i = 0; i + 1 < cand_cnt; i++) begin
                cand_val[i] = cand_val[i + 1];
                cand_pos[i] = cand_pos[i + 1];
            end
            cand_cnt = MAX_WINDOW - 1;
        end
        cand_val[cand_cnt] = s;
        cand_pos[cand_cnt] = pos;
        cand_cnt++;
        pos_ctr = pos + 1'b1;
        if (fill_cnt < MAX_WINDOW) fill_cnt++;
        has_max = (fill_cnt >= w);
        max_val = cand_val[0];
    endfunction

    // many small values so that ties are common, plus full-range values and extremes
    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return SAMPLE_WIDTH'(int'($urandom_range(16)) - 8);
        if (sel < 85) return SAMPLE_WIDTH'($urandom);
        if (sel < 93) return 32'sh7FFF_FFFF - SAMPLE_WIDTH'($urandom_range(3));
        return 32'sh8000_0000 + SAMPLE_WIDTH'($urandom_range(3));
    endfunction

    // offer one item, hold it until accepted, then record what it should produce
    task automatic send_item(input logic signed [SAMPLE_WIDTH-1:0] s, input logic st,
                             input t_check check, input logic signed [SAMPLE_WIDTH-1:0] want);
        bit                             has_max;
        logic signed [SAMPLE_WIDTH-1:0] max_val;
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= s;
        in_ch.start_req <= st;
        do @(posedge i_clk); while (!in_ch.ready);
        advance_window(s, st, has_max, max_val);
        case (check)
            CHECK_MODEL: if (has_max) exp_put(max_val);
            CHECK_VALUE: exp_put(want);
            default: ;
        endcase
    endtask

    // drain, let the last item finish, then write window_size
    task automatic write_window(input logic [CFG_WIDTH-1:0] ws);
        in_ch.valid <= 1'b0;
        while (exp_level != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= ws;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        win_reg = ws;
    endtask

    // result side: random stalls, compare each accepted item with the oldest expectation
    initial begin
        logic signed [SAMPLE_WIDTH-1:0] want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (exp_level == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, out_ch.window_max);
                    mismatch_cnt++;
                end else begin
                    want = exp_get();
                    if (out_ch.window_max !== want) begin
                        $display("%0t: window_max mismatch, expected %0d, actual %0d",
                                 $time, want, out_ch.window_max);
                        mismatch_cnt++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // stimulus
    initial begin
        int                             n_rand;
        int                             phase;
        int                             n_phase;
        int                             w_eff;
        int                             shape;
        logic [CFG_WIDTH-1:0]           ws;
        logic signed [SAMPLE_WIDTH-1:0] s;
        logic signed [SAMPLE_WIDTH-1:0] ramp;
        logic                           st;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample       <= '0;
        in_ch.start_req    <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.window_size <= 7'd1;
        cand_cnt      = 0;
        fill_cnt      = 0;
        pos_ctr       = '0;
        win_reg       = 7'd1;
        exp_wr        = 0;
        exp_rd        = 0;
        exp_level     = 0;
        mismatch_cnt  = 0;
        send_idle_pct = 27;
        recv_idle_pct = 84;
        n_rand        = 0;
        phase         = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_window(dir_rows[r].win);
            end else begin
                send_item(dir_rows[r].sample, dir_rows[r].start, dir_rows[r].check,
                          dir_rows[r].want);
            end
        end

        // random phases: one window setting each, corners first
        while (n_rand < RAND_ITEMS) begin
            if (phase < N_CORNER) begin
                ws = corner_windows[phase];
            end else if ($urandom_range(99) < 70) begin
                ws = CFG_WIDTH'($urandom_range(1, 16));
            end else if ($urandom_range(99) < 67) begin
                ws = CFG_WIDTH'($urandom_range(17, MAX_WINDOW));
            end else begin
                ws = CFG_WIDTH'($urandom_range(0, 127));
            end
            write_window(ws);
            w_eff   = (ws == 0) ? 1 : ((ws > MAX_WINDOW) ? MAX_WINDOW : int'(ws));
            n_phase = w_eff + $urandom_range(4, 60);
            shape   = $urandom_range(3);
            ramp    = rand_sample();
            for (int k = 0; k < n_phase; k++) begin
                if (n_rand < RAND_ITEMS / 3) begin
                    send_idle_pct = 27;
                    recv_idle_pct = 84;
                end else if (n_rand < 2 * RAND_ITEMS / 3) begin
                    send_idle_pct = 84;
                    recv_idle_pct = 27;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                st = (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 2);
                // descending ramps fill the queue, ascending ones empty it from the back
                case (shape)
                    2: begin
                        ramp = ramp - SAMPLE_WIDTH'($urandom_range(3));
                        s    = ramp;
                    end
                    3: begin
                        ramp = ramp + SAMPLE_WIDTH'($urandom_range(3));
                        s    = ramp;
                    end
                    default: s = rand_sample();
                endcase
                send_item(s, st, CHECK_MODEL, '0);
                n_rand++;
            end
            phase++;
        end

        // drain and let the block settle
        in_ch.valid <= 1'b0;
        while (exp_level != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
sv/swm_pkg.sv
sv/swm_if.sv
sv/swm_queue_mem.sv
sv/sliding_window_maximum_top.sv
sv/swm_checker.sv
test/tb_top.sv
